// ===== src/abrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_pkg: shared types and constants of the banked register file
// Access kinds, processor mode encodings, PSR protection masks and the
// command struct that passes from the controller to the datapath.
// ----------------------------------------------------------------------------
package abrf_pkg;

  // Access kinds carried by each request transaction.
  typedef enum logic [2:0] {
    KIND_READ_REG   = 3'd0,
    KIND_WRITE_REG  = 3'd1,
    KIND_READ_USER  = 3'd2,
    KIND_WRITE_USER = 3'd3,
    KIND_READ_CPSR  = 3'd4,
    KIND_WRITE_CPSR = 3'd5,
    KIND_READ_SPSR  = 3'd6,
    KIND_WRITE_SPSR = 3'd7
  } kind_t;

  // Processor mode encodings in CPSR[4:0].
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Bits that a PSR write leaves untouched.
  localparam logic [31:0] MASK_PRIV = 32'h07F0_FC20;
  localparam logic [31:0] MASK_USER = 32'h07F0_FDFF;

  // CPSR value after reset: system mode.
  localparam logic [31:0] CPSR_RESET = 32'h0000_001F;

  // Storage sizes.
  localparam int USER_DEPTH = 16;
  localparam int BANK_DEPTH = 15;
  localparam int SPSR_DEPTH = 5;

  // Base of each mode's R14/R13 pair in the mode bank.
  localparam logic [3:0] BASE_SVC = 4'd0;
  localparam logic [3:0] BASE_ABT = 4'd2;
  localparam logic [3:0] BASE_UND = 4'd4;
  localparam logic [3:0] BASE_IRQ = 4'd6;

  // Saved PSR slots.
  localparam logic [2:0] SLOT_SVC = 3'd0;
  localparam logic [2:0] SLOT_ABT = 3'd1;
  localparam logic [2:0] SLOT_UND = 3'd2;
  localparam logic [2:0] SLOT_IRQ = 3'd3;
  localparam logic [2:0] SLOT_FIQ = 3'd4;

  // Controller states: result register empty or holding a result.
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // perform the access and load the result register
  } cmd_t;

endpackage : abrf_pkg
`default_nettype wire

// ===== src/abrf_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_req_if: request channel of the banked register file
// Valid/ready channel carrying one register file access per transaction.
// ----------------------------------------------------------------------------
interface abrf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  reg_index;
  logic [31:0] write_data;

  modport source (output valid, output kind, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input kind, input reg_index, input write_data,
                  output ready);
endinterface : abrf_req_if
`default_nettype wire

// ===== src/abrf_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_rsp_if: response channel of the banked register file
// Valid/ready channel carrying read data and mode flags per transaction.
// ----------------------------------------------------------------------------
interface abrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [4:0]  cpsr_mode;
  logic        privileged;
  logic        has_saved_psr;

  modport source (output valid, output read_data, output cpsr_mode,
                  output privileged, output has_saved_psr, input ready);
  modport sink   (input valid, input read_data, input cpsr_mode,
                  input privileged, input has_saved_psr, output ready);
endinterface : abrf_rsp_if
`default_nettype wire

// ===== src/arm_banked_register_file_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_banked_register_file_core: ARMv5 register file with mode banking
// One access per request transaction through the banking of CPSR[4:0],
// answered by one response transaction with read data and mode flags.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req      in         kind, reg_index, write_data
//  rsp      out        read_data, cpsr_mode, privileged, has_saved_psr
//
// An accepted access updates the state and loads the response register in
// the same cycle; the response is offered from the next cycle on.
// A new request is accepted each cycle while the response register is empty
// or its response is taken in that cycle, so throughput is one per cycle.
// Reset clears all general registers and saved PSRs and puts CPSR in system mode.
// A stalled response holds the request side until it is taken.
// ----------------------------------------------------------------------------
module arm_banked_register_file_core (
  input  wire logic   clk,
  input  wire logic   rst,
  abrf_req_if.sink    req,
  abrf_rsp_if.source  rsp
);
  import abrf_pkg::*;

  cmd_t cmd;

  // Handshake controller.
  abrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Register storage and access datapath.
  abrf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (req.kind),
    .reg_index     (req.reg_index),
    .write_data    (req.write_data),
    .read_data     (rsp.read_data),
    .cpsr_mode     (rsp.cpsr_mode),
    .privileged    (rsp.privileged),
    .has_saved_psr (rsp.has_saved_psr)
  );

  // An executed access is offered as a response in the next cycle.
  a_exec_to_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp.valid)
    else $error("executed access did not produce a response");

  // A waiting response is never overwritten by a new access.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request accepted while response stalled");

  // User mode never reports a saved PSR.
  a_user_no_spsr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.privileged) |-> !rsp.has_saved_psr)
    else $error("user mode reported a saved PSR");

  // Reset leaves no response pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("response valid after reset");

endmodule : arm_banked_register_file_core
`default_nettype wire

// ===== src/abrf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_ctrl: handshake controller of the banked register file
// Tracks whether the result register holds an undelivered response and
// issues the execute command when a request transaction is accepted.
// ----------------------------------------------------------------------------
module abrf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output abrf_pkg::cmd_t     cmd
);
  import abrf_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a new access refills the result register, a delivery empties it.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (req_valid) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (rsp_ready && !req_valid) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  // Outputs: accept whenever the result register is free or being drained.
  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    unique case (state)
      ST_EMPTY: begin
        req_ready = 1'b1;
      end
      ST_FULL: begin
        req_ready = rsp_ready;
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
    cmd.exec = req_valid && req_ready;
  end

endmodule : abrf_ctrl
`default_nettype wire

// ===== src/abrf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_datapath: banked register storage and access logic
// Holds the user bank, the mode banks, CPSR and the saved PSRs, decodes the
// banking of the current mode and registers the response fields.
// ----------------------------------------------------------------------------
module abrf_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire abrf_pkg::cmd_t cmd,
  input  wire logic [2:0]     kind,
  input  wire logic [3:0]     reg_index,
  input  wire logic [31:0]    write_data,
  output logic [31:0]         read_data,
  output logic [4:0]          cpsr_mode,
  output logic                privileged,
  output logic                has_saved_psr
);
  import abrf_pkg::*;

  logic [31:0] user_bank  [USER_DEPTH];
  logic [31:0] mode_bank  [BANK_DEPTH];
  logic [31:0] saved_psr  [SPSR_DEPTH];
  logic [31:0] cpsr;

  logic [4:0]  mode;
  logic        mode_has_spsr;
  logic        use_mode_bank;
  logic [3:0]  bank_sel;
  logic [3:0]  bank_base;
  logic [2:0]  spsr_slot;
  logic [31:0] cell_data;
  logic [31:0] spsr_data;
  logic [31:0] rd;
  logic [31:0] cpsr_next;
  logic [31:0] cpsr_mask;
  logic [4:0]  mode_after;
  logic        wr_reg;
  logic        wr_user;
  logic        wr_spsr;

  // Mode decode from the current CPSR.
  assign mode          = cpsr[4:0];
  assign mode_has_spsr = (mode != MODE_USR) && (mode != MODE_SYS);

  // Saved PSR slot; unknown privileged modes share the FIQ slot.
  always_comb begin
    unique case (mode)
      MODE_SVC: spsr_slot = SLOT_SVC;
      MODE_ABT: spsr_slot = SLOT_ABT;
      MODE_UND: spsr_slot = SLOT_UND;
      MODE_IRQ: spsr_slot = SLOT_IRQ;
      default:  spsr_slot = SLOT_FIQ;
    endcase
  end

  // R13/R14 pair base; unknown privileged modes use the IRQ pair.
  always_comb begin
    unique case (mode)
      MODE_SVC: bank_base = BASE_SVC;
      MODE_ABT: bank_base = BASE_ABT;
      MODE_UND: bank_base = BASE_UND;
      default:  bank_base = BASE_IRQ;
    endcase
  end

  // Banked cell selection for the general register kinds.
  always_comb begin
    use_mode_bank = 1'b0;
    bank_sel      = reg_index;
    if (reg_index[3] && (reg_index != 4'd15) && mode_has_spsr) begin
      if (mode == MODE_FIQ) begin
        // FIQ banks R8 to R14 at the matching mode bank positions.
        use_mode_bank = 1'b1;
        bank_sel      = reg_index;
      end else if (reg_index >= 4'd13) begin
        // R13 takes the odd entry of the pair, R14 the even one.
        use_mode_bank = 1'b1;
        bank_sel      = bank_base + {3'd0, reg_index[0]};
      end
    end
  end

  assign cell_data = use_mode_bank ? mode_bank[bank_sel] : user_bank[reg_index];
  assign spsr_data = mode_has_spsr ? saved_psr[spsr_slot] : 32'd0;

  // Access decode: read data, write enables and the next CPSR.
  assign cpsr_mask = (mode != MODE_USR) ? MASK_PRIV : MASK_USER;

  always_comb begin
    rd        = 32'd0;
    cpsr_next = cpsr;
    wr_reg    = 1'b0;
    wr_user   = 1'b0;
    wr_spsr   = 1'b0;
    unique case (kind_t'(kind))
      KIND_READ_REG:   rd      = cell_data;
      KIND_WRITE_REG:  wr_reg  = 1'b1;
      KIND_READ_USER:  rd      = user_bank[reg_index];
      KIND_WRITE_USER: wr_user = 1'b1;
      KIND_READ_CPSR:  rd      = cpsr;
      KIND_WRITE_CPSR: cpsr_next = (cpsr & cpsr_mask) | (write_data & ~cpsr_mask);
      KIND_READ_SPSR:  rd      = spsr_data;
      KIND_WRITE_SPSR: wr_spsr = mode_has_spsr;
      default:         rd      = 32'd0;
    endcase
  end

  assign mode_after = cpsr_next[4:0];

  // Architectural state update on an executed access.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USER_DEPTH; i++) user_bank[i] <= 32'd0;
      for (int i = 0; i < BANK_DEPTH; i++) mode_bank[i] <= 32'd0;
      for (int i = 0; i < SPSR_DEPTH; i++) saved_psr[i] <= 32'd0;
      cpsr <= CPSR_RESET;
    end else if (cmd.exec) begin
      cpsr <= cpsr_next;
      if (wr_user || (wr_reg && !use_mode_bank)) begin
        user_bank[reg_index] <= write_data;
      end
      if (wr_reg && use_mode_bank) begin
        mode_bank[bank_sel] <= write_data;
      end
      if (wr_spsr) begin
        saved_psr[spsr_slot] <= (saved_psr[spsr_slot] & MASK_PRIV) |
                                (write_data & ~MASK_PRIV);
      end
    end
  end

  // Result register; flags reflect the mode after the access.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data     <= rd;
      cpsr_mode     <= mode_after;
      privileged    <= (mode_after != MODE_USR);
      has_saved_psr <= (mode_after != MODE_USR) && (mode_after != MODE_SYS);
    end
  end

endmodule : abrf_datapath
`default_nettype wire
